// ===== sv/pchd_pkg.sv =====
`timescale 1ns / 1ps

package pchd_pkg;

  // Input item kinds, carried on in_tuser
  localparam logic OP_SAMPLE    = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  // Configuration register indexes (byte address 4*index)
  localparam logic REG_MIN_INSTRUCTIONS = 1'b0;
  localparam logic REG_REPEAT_FRAMES    = 1'b1;

  // Field widths
  localparam int ADDR_W  = 24;
  localparam int OUT_CNT_W = 20;
  localparam int MIN_W   = 20;
  localparam int REP_W   = 4;
  localparam int OUT_W   = 72;

  // Multiplicative hash constant
  localparam logic [31:0] HASH_MULT = 32'd2654435769;

  // Register reset values
  localparam logic [MIN_W-1:0] MIN_RESET = 20'd100;
  localparam logic [REP_W-1:0] REP_RESET = 4'd3;

endpackage

// ===== sv/pchd_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write port, one read port, registered read.
module pchd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/program_counter_hang_detector_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// in_       slave      tvalid/tready      tuser: op; tdata: program_address
// out_      master     tvalid/tready      tdata: top_address, top_count,
//                                         frame_instructions, dominant_frames,
//                                         hang_detected
// cfg_      APB slave  psel/penable       min_instructions @0x0, repeat_frames @0x4
//
// Samples are taken one per cycle while in the run state: hash multiply,
// slot RAM read, then modify and write back, with one-deep forwarding for
// back-to-back hits on the same slot. A frame-end item drains the sample
// pipeline, then reads every slot of the slot RAM (the scan, which also
// clears each slot), then a tail step for the last read and a decide step.
// After reset a clearing pass writes every slot empty, during which no item is
// accepted. A waiting result does not block samples; the next frame-end result
// waits until the output register is free.
module program_counter_hang_detector_unit #(
  parameter int SLOT_COUNT = 64,
  parameter int COUNT_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] program_address
  input  logic        in_tuser,   // [0] op
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [23:0] top_address, [43:24] top_count,
                                  // [63:44] frame_instructions,
                                  // [67:64] dominant_frames, [68] hang_detected
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W = $clog2(SLOT_COUNT);
  localparam int AW    = pchd_pkg::ADDR_W;
  localparam int ENT_W = 1 + AW + COUNT_BITS;
  localparam int CMP_W = (COUNT_BITS > pchd_pkg::MIN_W) ? COUNT_BITS : pchd_pkg::MIN_W;
  localparam logic [IDX_W:0]   SLOT_EXT = (IDX_W + 1)'(SLOT_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_RUN    = 3'd1;
  localparam logic [2:0] ST_DRAIN  = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_TAIL   = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;

  logic [2:0] state_r, state_nxt;

  // configuration registers
  logic [pchd_pkg::MIN_W-1:0] min_r;
  logic [pchd_pkg::REP_W-1:0] rep_r;

  // frame state
  logic [COUNT_BITS-1:0] ic_r;
  logic [AW-1:0]         last_top_r;
  logic [3:0]            same_r;
  logic                  hang_r;

  // sample pipeline
  logic                  s1_v_r, s2_v_r, fwd_v_r;
  logic [AW-1:0]         s1_addr_r, s2_addr_r;
  logic [31:0]           s1_prod_r;
  logic [IDX_W-1:0]      s2_idx_r, s1_idx;
  logic [ENT_W-1:0]      fwd_data_r;

  // scan
  logic [IDX_W-1:0]      scan_idx_r, sc_idx_r;
  logic                  sc_pend_r;
  logic [AW-1:0]         best_addr_r;
  logic [COUNT_BITS-1:0] best_cnt_r;

  // output register
  logic                  out_v_r;
  logic [71:0]           out_data_r;

  // RAM ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENT_W-1:0]      ram_wdata, ram_rdata;

  logic in_fire, out_free, cfg_wr;
  assign in_fire  = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_RUN);
  assign out_free = !out_v_r || out_tready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;

  // register read-back
  always_comb begin
    unique case (cfg_paddr[2])
      pchd_pkg::REG_MIN_INSTRUCTIONS: cfg_prdata = 32'(min_r);
      pchd_pkg::REG_REPEAT_FRAMES:    cfg_prdata = 32'(rep_r);
      default:                        cfg_prdata = 32'd0;
    endcase
  end

  // hash: product mod 2^32, top bits, fold indexes past the table
  logic [31:0]    prod_in;
  logic [IDX_W:0] idx_ext;
  assign prod_in = {8'd0, in_tdata[23:0]} * pchd_pkg::HASH_MULT;
  assign idx_ext = {1'b0, s1_prod_r[31 -: IDX_W]};
  assign s1_idx  = (idx_ext >= SLOT_EXT) ? IDX_W'(idx_ext - SLOT_EXT) : idx_ext[IDX_W-1:0];

  // stage 2 read-modify-write of a slot
  logic [ENT_W-1:0]      cur_ent, new_ent;
  logic                  cur_v;
  logic [AW-1:0]         cur_addr;
  logic [COUNT_BITS-1:0] cur_cnt;
  assign cur_ent  = fwd_v_r ? fwd_data_r : ram_rdata;
  assign cur_v    = cur_ent[ENT_W-1];
  assign cur_addr = cur_ent[ENT_W-2 -: AW];
  assign cur_cnt  = cur_ent[COUNT_BITS-1:0];

  always_comb begin
    if (!cur_v) begin
      new_ent = {1'b1, s2_addr_r, COUNT_BITS'(1)};
    end else if (cur_addr == s2_addr_r && !(&cur_cnt)) begin
      new_ent = {1'b1, cur_addr, cur_cnt + COUNT_BITS'(1)};
    end else begin
      new_ent = cur_ent;
    end
  end

  // RAM port selection; the cases never overlap
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = s2_idx_r;
    ram_wdata = new_ent;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = scan_idx_r;
      ram_wdata = '0;
    end else if (sc_pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = sc_idx_r;
      ram_wdata = '0;
    end else if (s2_v_r) begin
      ram_we    = 1'b1;
    end
  end
  assign ram_raddr = (state_r == ST_SCAN) ? scan_idx_r : s1_idx;

  pchd_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOT_COUNT)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // scan compare on returned entry
  logic                  sc_take;
  assign sc_take = sc_pend_r && ram_rdata[ENT_W-1] &&
                   (ram_rdata[COUNT_BITS-1:0] > best_cnt_r);

  // frame-end decision
  logic [CMP_W-1:0] ic_ext, min_ext;
  logic             dom;
  logic [3:0]       same_new;
  logic [AW-1:0]    last_new;
  logic             pulse;
  assign ic_ext  = CMP_W'(ic_r);
  assign min_ext = CMP_W'(min_r);
  assign dom     = (ic_ext > min_ext) && (best_cnt_r > (ic_r >> 1));

  always_comb begin
    same_new = 4'd0;
    last_new = '0;
    pulse    = 1'b0;
    if (dom) begin
      if (best_addr_r == last_top_r) begin
        same_new = (&same_r) ? same_r : same_r + 4'd1;
        last_new = last_top_r;
      end else begin
        same_new = 4'd1;
        last_new = best_addr_r;
      end
      pulse = (same_new >= rep_r) && !hang_r;
    end
  end

  logic [CMP_W-1:0] top_cnt_ext;
  assign top_cnt_ext = CMP_W'(best_cnt_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (scan_idx_r == LAST_IDX) state_nxt = ST_RUN;
      ST_RUN:    if (in_fire && in_tuser == pchd_pkg::OP_FRAME_END) state_nxt = ST_DRAIN;
      ST_DRAIN:  if (!s1_v_r && !s2_v_r) state_nxt = ST_SCAN;
      ST_SCAN:   if (scan_idx_r == LAST_IDX) state_nxt = ST_TAIL;
      ST_TAIL:   state_nxt = ST_DECIDE;
      ST_DECIDE: if (out_free) state_nxt = ST_RUN;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      scan_idx_r <= '0;
      min_r      <= pchd_pkg::MIN_RESET;
      rep_r      <= pchd_pkg::REP_RESET;
      ic_r       <= '0;
      last_top_r <= '0;
      same_r     <= '0;
      hang_r     <= 1'b0;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      fwd_v_r    <= 1'b0;
      sc_pend_r  <= 1'b0;
      out_v_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_wr) begin
        unique case (cfg_paddr[2])
          pchd_pkg::REG_MIN_INSTRUCTIONS: min_r <= cfg_pwdata[pchd_pkg::MIN_W-1:0];
          pchd_pkg::REG_REPEAT_FRAMES:    rep_r <= cfg_pwdata[pchd_pkg::REP_W-1:0];
          default: ;
        endcase
      end

      // slot counter for clearing pass and scan
      if (state_r == ST_CLEAR || state_r == ST_SCAN) begin
        scan_idx_r <= (scan_idx_r == LAST_IDX) ? '0 : scan_idx_r + IDX_W'(1);
      end

      // sample pipeline and forwarding
      s1_v_r  <= in_fire && in_tuser == pchd_pkg::OP_SAMPLE;
      s2_v_r  <= s1_v_r;
      fwd_v_r <= s1_v_r && s2_v_r && (s1_idx == s2_idx_r);
      sc_pend_r <= (state_r == ST_SCAN);

      if (in_fire && in_tuser == pchd_pkg::OP_SAMPLE && !(&ic_r)) begin
        ic_r <= ic_r + COUNT_BITS'(1);
      end

      // result handshake and frame bookkeeping
      if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
      if (state_r == ST_DECIDE && out_free) begin
        out_v_r    <= 1'b1;
        ic_r       <= '0;
        same_r     <= same_new;
        last_top_r <= last_new;
        if (pulse) begin
          hang_r <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r <= in_tdata[23:0];
      s1_prod_r <= prod_in;
    end
    s2_addr_r  <= s1_addr_r;
    s2_idx_r   <= s1_idx;
    fwd_data_r <= new_ent;
    sc_idx_r   <= scan_idx_r;

    if (state_r == ST_DRAIN) begin
      best_cnt_r  <= '0;
      best_addr_r <= '0;
    end else if (sc_take) begin
      best_cnt_r  <= ram_rdata[COUNT_BITS-1:0];
      best_addr_r <= ram_rdata[ENT_W-2 -: AW];
    end

    if (state_r == ST_DECIDE && out_free) begin
      out_data_r <= {3'd0, pulse, same_new, ic_ext[pchd_pkg::OUT_CNT_W-1:0],
                     top_cnt_ext[pchd_pkg::OUT_CNT_W-1:0], best_addr_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // the scan starts only after the sample pipeline is empty
  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (!s1_v_r && !s2_v_r))
    else $error("slot scan overlaps sample pipeline");

  // scan clears never collide with a sample write-back
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(sc_pend_r && s2_v_r))
    else $error("scan clear and sample write in one cycle");

  // forwarded data is only held for a live stage-2 sample
  a_fwd_live: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_v_r |-> s2_v_r)
    else $error("forward flag without stage-2 sample");

  // a result appears only from the decide step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(state_r == ST_DECIDE))
    else $error("result raised outside decide step");

endmodule

// ===== sim/program_counter_hang_detector_unit_tb.sv =====
`timescale 1ns / 1ps

module program_counter_hang_detector_unit_tb;

  localparam int SLOTS = 64;
  localparam logic [19:0] CNT_MAX = 20'hFFFFF;
  localparam int SETTLE_CYCLES = SLOTS + 16;

  typedef struct packed {
    logic        op;
    logic [23:0] addr;
  } stim_t;

  typedef struct packed {
    logic [23:0] top_address;
    logic [19:0] top_count;
    logic [19:0] frame_instructions;
    logic [3:0]  dominant_frames;
    logic        hang_detected;
  } frame_report_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        in_tuser = pchd_pkg::OP_SAMPLE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // stimulus and expected reports
  stim_t         pending[$];
  frame_report_t reports_due[$];
  int unsigned   mismatches = 0;
  int unsigned   reports_seen = 0;
  logic          in_fire = 1'b0;
  logic          out_fire = 1'b0;
  int unsigned   tx_wait = 0;
  int unsigned   rx_wait = 0;
  int unsigned   hold_left = 0;
  logic          hold_done = 1'b0;
  logic [10:0]   calm_ctr = '0;
  logic [23:0]   hot_addr = 24'h00ABCD;
  logic [23:0]   addr_pool[8];

  // shadow copy of the detector
  logic [23:0] sh_slot_addr[SLOTS];
  logic [19:0] sh_slot_cnt[SLOTS];
  logic        sh_slot_vld[SLOTS];
  logic [19:0] sh_instr = '0;
  logic [23:0] sh_last_top = '0;
  logic [3:0]  sh_same_frames = '0;
  logic        sh_hang_seen = 1'b0;
  logic [19:0] sh_min_instr = pchd_pkg::MIN_RESET;
  logic [3:0]  sh_repeat = pchd_pkg::REP_RESET;

  program_counter_hang_detector_unit DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #5 clk = ~clk;

  // top six bits of the multiplicative hash
  function automatic logic [5:0] slot_of(logic [23:0] a);
    logic [31:0] p;
    p = {8'd0, a} * pchd_pkg::HASH_MULT;
    return p[31:26];
  endfunction

  // per-item wait: none during calm stretches
  function automatic int unsigned draw_wait();
    if (calm_ctr < 11'd200) return 0;
    return $urandom_range(0, 9);
  endfunction

  task automatic queue_item(input logic op, input logic [23:0] a);
    pending.insert(pending.size(), stim_t'({op, a}));
  endtask

  // register write, then read back
  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_pwrite = 1'b0;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== val) begin
      $error("cfg_prdata: expected %h, got %h", val, cfg_prdata);
      mismatches++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (idx == pchd_pkg::REG_MIN_INSTRUCTIONS) sh_min_instr = val[19:0];
    else sh_repeat = val[3:0];
  endtask

  // wait for every item and report, then let the block settle
  task automatic drain();
    while (pending.size() != 0 || in_tvalid || reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // frames of random shape: mostly one hot address, some noise, empty and open runs
  task automatic queue_random_frames(input int unsigned target);
    int unsigned queued, n, pct, r, j;
    logic [23:0] a;
    queued = 0;
    while (queued < target) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 9) == 0) n = $urandom_range(40, 300);
      else n = $urandom_range(1, 40);
      if (r < 65) begin
        pct = $urandom_range(55, 100);
        if ($urandom_range(0, 4) == 0)
          hot_addr = $urandom_range(0, 1) ? addr_pool[$urandom_range(0, 7)] : 24'($urandom);
      end else if (r < 80) begin
        pct = $urandom_range(0, 60);
      end else if (r < 90) begin
        n = 0;
        pct = 0;
      end else begin
        n = $urandom_range(1, 8);
        pct = 50;
      end
      for (j = 0; j < n; j++) begin
        if ($urandom_range(0, 99) < pct) a = hot_addr;
        else if ($urandom_range(0, 1)) a = addr_pool[$urandom_range(0, 7)];
        else a = 24'($urandom);
        queue_item(pchd_pkg::OP_SAMPLE, a);
      end
      queued += n;
      if (r < 90) begin
        queue_item(pchd_pkg::OP_FRAME_END, 24'($urandom));
        queued++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      sh_slot_addr[i] = '0;
      sh_slot_cnt[i] = '0;
      sh_slot_vld[i] = 1'b0;
    end
  end

  // free-running window that gives stretches with no idling
  always @(negedge clk) calm_ctr <= calm_ctr + 11'd1;

  // sender: next item after an accept or a wait
  always @(negedge clk) begin
    stim_t nxt;
    if (rst_n && !(in_tvalid && !in_fire)) begin
      if (tx_wait > 0) begin
        tx_wait = tx_wait - 1;
        in_tvalid <= 1'b0;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= nxt.op;
        in_tdata <= nxt.addr;
        tx_wait = draw_wait();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // one long hold-off on the result side so the block backs up
  always @(negedge clk) begin
    if (!hold_done && reports_seen == 12) begin
      hold_left <= 600;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver: random wait after each accepted report
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_fire) rx_wait = draw_wait();
      else if (rx_wait > 0) rx_wait = rx_wait - 1;
      out_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // predict on accepted items, check accepted reports
  always @(posedge clk) begin
    logic [5:0]    s;
    logic [23:0]   best_addr;
    logic [19:0]   best_cnt;
    logic          pulse;
    frame_report_t exp_r;
    in_fire <= in_tvalid && in_tready;
    out_fire <= out_tvalid && out_tready;

    if (rst_n && in_tvalid && in_tready) begin
      if (in_tuser == pchd_pkg::OP_SAMPLE) begin
        s = slot_of(in_tdata);
        if (sh_slot_vld[s]) begin
          if (sh_slot_addr[s] == in_tdata && sh_slot_cnt[s] != CNT_MAX)
            sh_slot_cnt[s] = sh_slot_cnt[s] + 20'd1;
        end else begin
          // empty slot is claimed; collisions fall through above
          sh_slot_vld[s] = 1'b1;
          sh_slot_addr[s] = in_tdata;
          sh_slot_cnt[s] = 20'd1;
        end
        if (sh_instr != CNT_MAX) sh_instr = sh_instr + 20'd1;
      end else begin
        // scan: strict greater keeps the lowest index on ties
        best_addr = '0;
        best_cnt = '0;
        pulse = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
          if (sh_slot_vld[i] && sh_slot_cnt[i] > best_cnt) begin
            best_cnt = sh_slot_cnt[i];
            best_addr = sh_slot_addr[i];
          end
        end
        if (sh_instr > sh_min_instr && best_cnt > (sh_instr >> 1)) begin
          if (best_addr == sh_last_top) begin
            if (sh_same_frames != 4'd15) sh_same_frames = sh_same_frames + 4'd1;
          end else begin
            sh_same_frames = 4'd1;
            sh_last_top = best_addr;
          end
          if (sh_same_frames >= sh_repeat && !sh_hang_seen) begin
            sh_hang_seen = 1'b1;
            pulse = 1'b1;
          end
        end else begin
          sh_same_frames = '0;
          sh_last_top = '0;
        end
        exp_r.top_address = best_addr;
        exp_r.top_count = best_cnt;
        exp_r.frame_instructions = sh_instr;
        exp_r.dominant_frames = sh_same_frames;
        exp_r.hang_detected = pulse;
        reports_due.insert(reports_due.size(), exp_r);
        for (int i = 0; i < SLOTS; i++) sh_slot_vld[i] = 1'b0;
        sh_instr = '0;
      end
    end

    if (rst_n && out_tvalid && out_tready) begin
      reports_seen <= reports_seen + 1;
      if (reports_due.size() == 0) begin
        $error("report with none expected: tdata %h", out_tdata);
        mismatches++;
      end else begin
        exp_r = reports_due.pop_front();
        if (out_tdata[23:0] !== exp_r.top_address) begin
          $error("top_address: expected %h, got %h", exp_r.top_address, out_tdata[23:0]);
          mismatches++;
        end
        if (out_tdata[43:24] !== exp_r.top_count) begin
          $error("top_count: expected %0d, got %0d", exp_r.top_count, out_tdata[43:24]);
          mismatches++;
        end
        if (out_tdata[63:44] !== exp_r.frame_instructions) begin
          $error("frame_instructions: expected %0d, got %0d",
                 exp_r.frame_instructions, out_tdata[63:44]);
          mismatches++;
        end
        if (out_tdata[67:64] !== exp_r.dominant_frames) begin
          $error("dominant_frames: expected %0d, got %0d",
                 exp_r.dominant_frames, out_tdata[67:64]);
          mismatches++;
        end
        if (out_tdata[68] !== exp_r.hang_detected) begin
          $error("hang_detected: expected %0d, got %0d", exp_r.hang_detected, out_tdata[68]);
          mismatches++;
        end
      end
    end
  end

  // run limit
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // test sequence
  initial begin
    logic [23:0] coll;
    for (int i = 0; i < 8; i++) addr_pool[i] = 24'($urandom);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty frame, extremes, hang pulse and stickiness, collision, tie
    write_reg(pchd_pkg::REG_MIN_INSTRUCTIONS, 32'd0);
    write_reg(pchd_pkg::REG_REPEAT_FRAMES, 32'd2);
    queue_item(pchd_pkg::OP_FRAME_END, 24'h000000);
    queue_item(pchd_pkg::OP_SAMPLE, 24'h000000);
    queue_item(pchd_pkg::OP_SAMPLE, 24'hFFFFFF);
    queue_item(pchd_pkg::OP_SAMPLE, 24'hFFFFFF);
    queue_item(pchd_pkg::OP_FRAME_END, 24'hFFFFFF);
    queue_item(pchd_pkg::OP_SAMPLE, 24'hFFFFFF);
    queue_item(pchd_pkg::OP_SAMPLE, 24'hFFFFFF);
    queue_item(pchd_pkg::OP_FRAME_END, 24'h5A5A5A);
    queue_item(pchd_pkg::OP_SAMPLE, 24'hFFFFFF);
    queue_item(pchd_pkg::OP_FRAME_END, 24'hA5A5A5);
    coll = 24'h123457;
    while (slot_of(coll) != slot_of(24'h123456)) coll = coll + 24'd1;
    queue_item(pchd_pkg::OP_SAMPLE, 24'h123456);
    queue_item(pchd_pkg::OP_SAMPLE, coll);
    queue_item(pchd_pkg::OP_SAMPLE, 24'h123456);
    queue_item(pchd_pkg::OP_FRAME_END, 24'h000000);
    queue_item(pchd_pkg::OP_SAMPLE, 24'h000001);
    queue_item(pchd_pkg::OP_SAMPLE, 24'h800000);
    queue_item(pchd_pkg::OP_FRAME_END, 24'h000000);
    drain();

    // random phases over several settings
    write_reg(pchd_pkg::REG_MIN_INSTRUCTIONS, $urandom_range(0, 30));
    write_reg(pchd_pkg::REG_REPEAT_FRAMES, $urandom_range(1, 15));
    queue_random_frames(500);
    drain();

    write_reg(pchd_pkg::REG_MIN_INSTRUCTIONS, 32'd0);
    write_reg(pchd_pkg::REG_REPEAT_FRAMES, 32'd0);
    queue_random_frames(500);
    drain();

    write_reg(pchd_pkg::REG_MIN_INSTRUCTIONS, 32'hFFFFF);
    write_reg(pchd_pkg::REG_REPEAT_FRAMES, 32'd15);
    queue_random_frames(500);
    drain();

    write_reg(pchd_pkg::REG_MIN_INSTRUCTIONS, $urandom_range(0, 30));
    write_reg(pchd_pkg::REG_REPEAT_FRAMES, $urandom_range(1, 15));
    queue_random_frames(500);
    drain();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
